// File: design/utxr_pkg.sv
// shared types and constants for the uart transmit ring
package utxr_pkg;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;
  localparam int OUT_CW = 10;

  localparam logic [1:0] REG_INBAND = 2'd0;
  localparam logic [1:0] REG_STOP   = 2'd1;
  localparam logic [1:0] REG_START  = 2'd2;

  localparam logic [7:0] STOP_CHAR_RESET  = 8'd19;
  localparam logic [7:0] START_CHAR_RESET = 8'd17;
  localparam logic [7:0] NO_FLOW_CHAR     = 8'd0;

  typedef enum logic [2:0] {
    OP_PUT        = 3'd0,
    OP_TX_SLOT    = 3'd1,
    OP_FLUSH      = 3'd2,
    OP_THROTTLE   = 3'd3,
    OP_UNTHROTTLE = 3'd4,
    OP_SEND_FLOW  = 3'd5,
    OP_STOP       = 3'd6,
    OP_START      = 3'd7
  } op_t;

  typedef struct packed {
    logic inband_flow_enable;
    logic [7:0] stop_character;
    logic [7:0] start_character;
  } cfg_t;

  typedef struct packed {
    logic accepted;
    logic tx_valid;
    logic from_mem;
    logic [7:0] tx_byte;
    logic [OUT_CW-1:0] free_space;
    logic [OUT_CW-1:0] bytes_queued;
    logic transmit_enabled;
  } res_t;

endpackage

// File: design/utxr_if.sv
// item and result channel interfaces
interface utxr_item_if;
  import utxr_pkg::*;
  logic valid;
  logic ready;
  op_t operation;
  logic [7:0] byte_in;
  modport source (output valid, output operation, output byte_in, input ready);
  modport sink (input valid, input operation, input byte_in, output ready);
endinterface

interface utxr_result_if;
  import utxr_pkg::*;
  logic valid;
  logic ready;
  logic accepted;
  logic tx_valid;
  logic [7:0] tx_byte;
  logic [OUT_CW-1:0] free_space;
  logic [OUT_CW-1:0] bytes_queued;
  logic transmit_enabled;
  modport source (output valid, output accepted, output tx_valid, output tx_byte,
                  output free_space, output bytes_queued, output transmit_enabled,
                  input ready);
  modport sink (input valid, input accepted, input tx_valid, input tx_byte,
                input free_space, input bytes_queued, input transmit_enabled,
                output ready);
endinterface

// File: design/utxr_regs.sv
// apb configuration registers
module utxr_regs
  import utxr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [1:0] idx;
  logic       wr;

  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inband_flow_enable <= 1'b0;
      cfg.stop_character     <= STOP_CHAR_RESET;
      cfg.start_character    <= START_CHAR_RESET;
    end else if (wr) begin
      case (idx)
        REG_INBAND: cfg.inband_flow_enable <= pwdata[0];
        REG_STOP:   cfg.stop_character     <= pwdata[7:0];
        REG_START:  cfg.start_character    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_INBAND: prdata = {{(APB_DW-1){1'b0}}, cfg.inband_flow_enable};
      REG_STOP:   prdata = {{(APB_DW-8){1'b0}}, cfg.stop_character};
      REG_START:  prdata = {{(APB_DW-8){1'b0}}, cfg.start_character};
      default:    prdata = '0;
    endcase
  end

endmodule

// File: design/utxr_ram.sv
// ring storage, one write and one registered read per cycle
module utxr_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/utxr_ctrl.sv
// ring pointers, flow slot and transmit enable, first result stage
module utxr_ctrl
  import utxr_pkg::*;
#(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic           clk,
  input  logic           rst,
  utxr_item_if.sink      item,
  input  cfg_t           cfg,
  output logic           we,
  output logic [AW-1:0]  waddr,
  output logic [7:0]     wdata,
  output logic           re,
  output logic [AW-1:0]  raddr,
  output logic           s1_valid,
  output res_t           s1,
  input  logic           s1_take
);

  localparam int CW = (AW > OUT_CW) ? AW : OUT_CW;
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [AW-1:0] wr_ptr, wr_ptr_next;
  logic [AW-1:0] rd_ptr, rd_ptr_next;
  logic [7:0]    pend, pend_next;
  logic          tx_en, tx_en_next;
  logic          acc;
  logic [AW-1:0] cnt, cnt_after, free_after;
  logic [CW-1:0] cnt_ext, free_ext;
  res_t          res;

  function automatic logic [AW-1:0] occ(input logic [AW-1:0] wp, input logic [AW-1:0] rp);
    logic [AW:0] d;
    d = {1'b0, wp} - {1'b0, rp};
    if (wp < rp) begin
      d = d + (AW+1)'(DEPTH);
    end
    return d[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] step(input logic [AW-1:0] p);
    return (p == LAST) ? '0 : p + AW'(1);
  endfunction

  assign item.ready = !s1_valid || s1_take;
  assign acc        = item.valid && item.ready;
  assign cnt        = occ(wr_ptr, rd_ptr);
  assign waddr      = wr_ptr;
  assign wdata      = item.byte_in;
  assign raddr      = rd_ptr;

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    pend_next   = pend;
    tx_en_next  = tx_en;
    we          = 1'b0;
    re          = 1'b0;
    res         = '0;
    case (item.operation)
      OP_PUT: begin
        if (cnt != LAST) begin
          we           = acc;
          wr_ptr_next  = step(wr_ptr);
          tx_en_next   = 1'b1;
          res.accepted = 1'b1;
        end
      end
      OP_TX_SLOT: begin
        if (tx_en) begin
          if (pend != NO_FLOW_CHAR) begin
            res.tx_valid = 1'b1;
            res.tx_byte  = pend;
            pend_next    = NO_FLOW_CHAR;
          end else if (cnt == '0) begin
            tx_en_next = 1'b0;
          end else begin
            res.tx_valid = 1'b1;
            res.from_mem = 1'b1;
            re           = acc;
            rd_ptr_next  = step(rd_ptr);
          end
        end
      end
      OP_FLUSH: begin
        wr_ptr_next = '0;
        rd_ptr_next = '0;
        tx_en_next  = (pend != NO_FLOW_CHAR);
      end
      OP_THROTTLE: begin
        if (cfg.inband_flow_enable) begin
          pend_next  = cfg.stop_character;
          tx_en_next = 1'b1;
        end
      end
      OP_UNTHROTTLE: begin
        if (cfg.inband_flow_enable) begin
          if (pend != NO_FLOW_CHAR) begin
            pend_next = NO_FLOW_CHAR;
          end else begin
            pend_next  = cfg.start_character;
            tx_en_next = 1'b1;
          end
        end
      end
      OP_SEND_FLOW: begin
        pend_next  = item.byte_in;
        tx_en_next = 1'b1;
      end
      OP_STOP: tx_en_next = 1'b0;
      OP_START: tx_en_next = 1'b1;
      default: ;
    endcase
    cnt_after            = occ(wr_ptr_next, rd_ptr_next);
    free_after           = LAST - cnt_after;
    cnt_ext              = CW'(cnt_after);
    free_ext             = CW'(free_after);
    res.bytes_queued     = cnt_ext[OUT_CW-1:0];
    res.free_space       = free_ext[OUT_CW-1:0];
    res.transmit_enabled = tx_en_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      pend     <= NO_FLOW_CHAR;
      tx_en    <= 1'b0;
      s1_valid <= 1'b0;
    end else begin
      if (acc) begin
        wr_ptr <= wr_ptr_next;
        rd_ptr <= rd_ptr_next;
        pend   <= pend_next;
        tx_en  <= tx_en_next;
      end
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1 <= res;
    end
  end

endmodule

// File: design/uart_tx_ring_with_xon_xoff_top.sv
// uart transmit ring with xon/xoff flow slot, top level
// a result is registered in the first stage and then in the output register after its item is accepted
// throughput: one item per cycle while the result output is not stalled, each item makes at most one ring memory access
// a stalled result is held in the output register while the next item waits in the first stage
// reset clears pointers, the pending flow character, transmit enable and configuration
// ring contents are not cleared by reset and need no clearing pass
module uart_tx_ring_with_xon_xoff_top
  import utxr_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  utxr_item_if.sink         item,
  utxr_result_if.source     result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = $clog2(DEPTH);

  cfg_t          cfg;
  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdata, rdata;
  logic          s1_valid, s1_take;
  res_t          s1;

  utxr_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  utxr_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  utxr_ctrl #(.DEPTH(DEPTH), .AW(AW)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .item     (item),
    .cfg      (cfg),
    .we       (we),
    .waddr    (waddr),
    .wdata    (wdata),
    .re       (re),
    .raddr    (raddr),
    .s1_valid (s1_valid),
    .s1       (s1),
    .s1_take  (s1_take)
  );

  assign s1_take = s1_valid && (!result.valid || result.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (s1_take) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take) begin
      result.accepted         <= s1.accepted;
      result.tx_valid         <= s1.tx_valid;
      result.tx_byte          <= s1.from_mem ? rdata : s1.tx_byte;
      result.free_space       <= s1.free_space;
      result.bytes_queued     <= s1.bytes_queued;
      result.transmit_enabled <= s1.transmit_enabled;
    end
  end

endmodule

// File: verif/utxr_ring_checker.sv
// checker for the uart transmit ring: watches the channels, predicts each result and compares
`timescale 1ns / 100ps

module utxr_ring_checker
  import utxr_pkg::*;
#(
  parameter int DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  utxr_item_if              item,
  utxr_result_if            result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  input  logic [APB_DW-1:0] prdata,
  input  logic              drained,
  output int                fails
);

  typedef struct packed {
    logic accepted;
    logic tx_valid;
    logic [7:0] tx_byte;
    logic [OUT_CW-1:0] free_space;
    logic [OUT_CW-1:0] bytes_queued;
    logic transmit_enabled;
  } uart_out_t;

  logic [7:0] ring_mem [DEPTH];
  int wr_ptr;
  int rd_ptr;
  logic [7:0] flow_char;
  logic tx_en;
  cfg_t cfg;
  uart_out_t expected_out[$];
  uart_out_t want;
  logic [APB_DW-1:0] reg_rd;
  bit drain_checked;

  function automatic int ring_fill();
    return (wr_ptr + DEPTH - rd_ptr) % DEPTH;
  endfunction

  function automatic uart_out_t apply_op(op_t op, logic [7:0] b);
    uart_out_t o;
    int cnt;
    o = '0;
    case (op)
      OP_PUT: begin
        if (ring_fill() < DEPTH - 1) begin
          ring_mem[wr_ptr] = b;
          wr_ptr = (wr_ptr + 1) % DEPTH;
          tx_en = 1'b1;
          o.accepted = 1'b1;
        end
      end
      OP_TX_SLOT: begin
        if (tx_en) begin
          if (flow_char != NO_FLOW_CHAR) begin
            o.tx_valid = 1'b1;
            o.tx_byte = flow_char;
            flow_char = NO_FLOW_CHAR;
          end else if (ring_fill() == 0) begin
            tx_en = 1'b0;
          end else begin
            o.tx_valid = 1'b1;
            o.tx_byte = ring_mem[rd_ptr];
            rd_ptr = (rd_ptr + 1) % DEPTH;
          end
        end
      end
      OP_FLUSH: begin
        wr_ptr = 0;
        rd_ptr = 0;
        tx_en = (flow_char != NO_FLOW_CHAR);
      end
      OP_THROTTLE: begin
        if (cfg.inband_flow_enable) begin
          flow_char = cfg.stop_character;
          tx_en = 1'b1;
        end
      end
      OP_UNTHROTTLE: begin
        if (cfg.inband_flow_enable) begin
          if (flow_char != NO_FLOW_CHAR) begin
            flow_char = NO_FLOW_CHAR;
          end else begin
            flow_char = cfg.start_character;
            tx_en = 1'b1;
          end
        end
      end
      OP_SEND_FLOW: begin
        flow_char = b;
        tx_en = 1'b1;
      end
      OP_STOP: tx_en = 1'b0;
      default: tx_en = 1'b1;
    endcase
    cnt = ring_fill();
    o.free_space = OUT_CW'(DEPTH - 1 - cnt);
    o.bytes_queued = OUT_CW'(cnt);
    o.transmit_enabled = tx_en;
    return o;
  endfunction

  task automatic check_field(string name, logic [APB_DW-1:0] exp_v, logic [APB_DW-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t %s: expected %0h, got %0h", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      wr_ptr = 0;
      rd_ptr = 0;
      flow_char = NO_FLOW_CHAR;
      tx_en = 1'b0;
      cfg = {1'b0, STOP_CHAR_RESET, START_CHAR_RESET};
      expected_out.delete();
      drain_checked = 1'b0;
      fails = 0;
    end else begin
      if (result.valid && result.ready) begin
        if (expected_out.size() == 0) begin
          $display("%0t result with no transaction pending: expected none, got byte %0h",
                   $time, result.tx_byte);
          fails++;
        end else begin
          want = expected_out.pop_front();
          check_field("accepted", APB_DW'(want.accepted), APB_DW'(result.accepted));
          check_field("tx_valid", APB_DW'(want.tx_valid), APB_DW'(result.tx_valid));
          check_field("tx_byte", APB_DW'(want.tx_byte), APB_DW'(result.tx_byte));
          check_field("free_space", APB_DW'(want.free_space), APB_DW'(result.free_space));
          check_field("bytes_queued", APB_DW'(want.bytes_queued), APB_DW'(result.bytes_queued));
          check_field("transmit_enabled", APB_DW'(want.transmit_enabled),
                      APB_DW'(result.transmit_enabled));
        end
      end
      if (item.valid && item.ready) expected_out.push_back(apply_op(item.operation, item.byte_in));
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr[APB_AW-1:2])
            REG_INBAND: cfg.inband_flow_enable = pwdata[0];
            REG_STOP:   cfg.stop_character = pwdata[7:0];
            REG_START:  cfg.start_character = pwdata[7:0];
            default: ;
          endcase
        end else begin
          case (paddr[APB_AW-1:2])
            REG_INBAND: reg_rd = APB_DW'(cfg.inband_flow_enable);
            REG_STOP:   reg_rd = APB_DW'(cfg.stop_character);
            REG_START:  reg_rd = APB_DW'(cfg.start_character);
            default:    reg_rd = prdata;
          endcase
          check_field("prdata", reg_rd, prdata);
        end
      end
      if (drained && !drain_checked) begin
        drain_checked = 1'b1;
        if (expected_out.size() != 0) begin
          $display("%0t %0d results expected, 0 received", $time, expected_out.size());
          fails += expected_out.size();
        end
      end
    end
  end

endmodule

// File: verif/uart_tx_ring_with_xon_xoff_top_test.sv
// testbench top for the uart transmit ring: stimulus, configuration phases and verdict
`timescale 1ns / 100ps

module uart_tx_ring_with_xon_xoff_top_test;
  import utxr_pkg::*;

  localparam int RING_DEPTH  = 1024;
  localparam int RAND_ITEMS  = 1330;
  localparam int PHASE_LEN   = (RAND_ITEMS + 3) / 4;
  localparam int FILL_FROM   = 60;
  localparam int FILL_TO     = 1120;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic pready;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic drained;
  int fails;
  int sent;
  int got;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  op_t op;

  utxr_item_if item_ch ();
  utxr_result_if result_ch ();

  always #6 clk = ~clk;

  uart_tx_ring_with_xon_xoff_top #(
    .DEPTH(RING_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  utxr_ring_checker #(
    .DEPTH(RING_DEPTH)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .item(item_ch),
    .result(result_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .drained(drained),
    .fails(fails)
  );

  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (result_ch.valid && result_ch.ready) got++;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_op(op_t o, logic [7:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.operation <= o;
    item_ch.byte_in <= b;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (got < sent) @(posedge clk);
  endtask

  task automatic apb_xfer(bit wr, logic [1:0] idx, logic [APB_DW-1:0] d);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= APB_AW'({idx, 2'b00});
    pwdata <= d;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic load_config(cfg_t c);
    apb_xfer(1'b1, REG_INBAND, APB_DW'(c.inband_flow_enable));
    apb_xfer(1'b1, REG_STOP, APB_DW'(c.stop_character));
    apb_xfer(1'b1, REG_START, APB_DW'(c.start_character));
    apb_xfer(1'b0, REG_INBAND, '0);
    apb_xfer(1'b0, REG_STOP, '0);
    apb_xfer(1'b0, REG_START, '0);
  endtask

  function automatic cfg_t phase_config(int ph);
    case (ph)
      0:       return {1'b1, 8'hFF, 8'h00};
      1:       return {1'b1, 8'h00, 8'hFF};
      2:       return {1'b0, 8'h5A, 8'hA5};
      default: return {1'b1, STOP_CHAR_RESET, START_CHAR_RESET};
    endcase
  endfunction

  // filling keeps almost every transaction a put and never flushes
  function automatic op_t pick_op(bit filling);
    int r;
    if (filling && $urandom_range(63) != 0) return OP_PUT;
    r = $urandom_range(99);
    if (r < 35) return OP_PUT;
    if (r < 70) return OP_TX_SLOT;
    if (r < 73) return filling ? OP_START : OP_FLUSH;
    if (r < 79) return OP_THROTTLE;
    if (r < 85) return OP_UNTHROTTLE;
    if (r < 90) return OP_SEND_FLOW;
    if (r < 95) return OP_STOP;
    return OP_START;
  endfunction

  function automatic logic [7:0] pick_byte(op_t o);
    if (o == OP_SEND_FLOW && $urandom_range(7) == 0) return NO_FLOW_CHAR;
    return 8'($urandom_range(255));
  endfunction

  initial begin
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.operation = OP_PUT;
    item_ch.byte_in = 8'h00;
    result_ch.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    drained = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    apb_xfer(1'b0, REG_INBAND, '0);
    apb_xfer(1'b0, REG_STOP, '0);
    apb_xfer(1'b0, REG_START, '0);

    // flow control off, transmit initially disabled
    send_op(OP_TX_SLOT, 8'h00);
    send_op(OP_THROTTLE, 8'h00);
    send_op(OP_UNTHROTTLE, 8'hFF);
    send_op(OP_PUT, 8'h00);
    send_op(OP_PUT, 8'hFF);
    send_op(OP_PUT, 8'hA5);
    send_op(OP_STOP, 8'h00);
    send_op(OP_TX_SLOT, 8'h00);
    send_op(OP_START, 8'h00);
    send_op(OP_TX_SLOT, 8'h00);
    send_op(OP_TX_SLOT, 8'h00);
    send_op(OP_SEND_FLOW, NO_FLOW_CHAR);
    send_op(OP_TX_SLOT, 8'h00);
    send_op(OP_TX_SLOT, 8'h00);
    send_op(OP_SEND_FLOW, 8'h7E);
    send_op(OP_PUT, 8'h3C);
    send_op(OP_TX_SLOT, 8'h00);
    send_op(OP_FLUSH, 8'h00);
    send_op(OP_SEND_FLOW, 8'h11);
    send_op(OP_FLUSH, 8'h00);
    send_op(OP_TX_SLOT, 8'h00);
    send_op(OP_TX_SLOT, 8'h00);

    // in-band flow control with a zero start character
    settle();
    load_config({1'b1, 8'h13, 8'h00});
    send_op(OP_THROTTLE, 8'h00);
    send_op(OP_UNTHROTTLE, 8'h00);
    send_op(OP_TX_SLOT, 8'h00);
    send_op(OP_UNTHROTTLE, 8'h00);
    send_op(OP_TX_SLOT, 8'h00);
    send_op(OP_THROTTLE, 8'h00);
    send_op(OP_TX_SLOT, 8'h00);

    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % PHASE_LEN == 0) begin
        settle();
        load_config(phase_config(k / PHASE_LEN));
        case (k / PHASE_LEN)
          0: begin
            send_idle_pct = 0;
            recv_stall_pct = 0;
          end
          1: begin
            send_idle_pct = 68;
            recv_stall_pct = 0;
          end
          2: begin
            send_idle_pct = 0;
            recv_stall_pct = 68;
          end
          default: begin
            send_idle_pct = 36;
            recv_stall_pct = 36;
          end
        endcase
      end
      op = pick_op(k >= FILL_FROM && k < FILL_TO);
      send_op(op, pick_byte(op));
    end

    settle();
    repeat (4) @(posedge clk);
    @(negedge clk);
    drained <= 1'b1;
    @(posedge clk);
    @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
